FILE: rtl/core/goldbach_prime_pair_search_macros.svh
// Assertion helpers for the top-level RTL
`ifndef GOLDBACH_PRIME_PAIR_SEARCH_MACROS_SVH
`define GOLDBACH_PRIME_PAIR_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GPPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define GPPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/gpps_pkg.sv
`default_nettype none
package gpps_pkg;

  localparam int NW      = 16;          // working number width
  localparam int DW      = NW / 2 + 2;  // trial divisor width
  localparam int CNTW    = $clog2(NW + 1);

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_NO_PAIR = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;       // capture request
    logic    init_cand;
    logic    next_cand;
    logic    v_cand;
    logic    v_comp;
    logic    d_three;
    logic    d_add2;
    logic    d_adv;
    logic    div_start;
    logic    write_out;
    status_t result;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic cand_end;
    logic comp_small;
    logic v_lt2;
    logic v_le3;
    logic v_even;
    logic sq_over;
    logic div_done;
    logic rem_zero;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/gpps_rem.sv
`default_nettype none
module gpps_rem (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [gpps_pkg::NW-1:0] dividend,
  input  wire logic [gpps_pkg::DW-1:0] divisor,
  output logic                        done,
  output logic [gpps_pkg::DW-1:0]     rem
);
  import gpps_pkg::*;

  logic [NW-1:0]   shreg;
  logic [DW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic            fits;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, shreg[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[NW-2:0], 1'b0};
      rem   <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gpps_dp.sv
`default_nettype none
module gpps_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire gpps_pkg::cmd_t          cmd,
  output gpps_pkg::stat_t              st,
  input  wire logic [15:0]             target,
  output logic [15:0]                  larger_prime,
  output logic [15:0]                  smaller_prime,
  output gpps_pkg::status_t            status
);
  import gpps_pkg::*;

  logic [NW-1:0]   n;
  logic [NW-1:0]   cand;
  logic [NW-1:0]   comp;
  logic [NW-1:0]   v;
  logic [DW-1:0]   d;
  logic [2*DW-1:0] sq;
  logic [DW-1:0]   rem;
  logic            found;

  assign comp  = n - cand;
  assign sq    = {{DW{1'b0}}, d} * {{DW{1'b0}}, d};
  assign found = cmd.result == STATUS_FOUND;

  assign st.invalid    = n[0] | (n <= NW'(2));
  assign st.cand_end   = cand == n;
  assign st.comp_small = comp[NW-1:1] == '0;
  assign st.v_lt2      = v < NW'(2);
  assign st.v_le3      = v <= NW'(3);
  assign st.v_even     = ~v[0];
  assign st.sq_over    = sq > (2*DW)'(v);
  assign st.rem_zero   = rem == '0;

  gpps_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(v),
    .divisor (d),
    .done    (st.div_done),
    .rem     (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load)      n <= target[NW-1:0];
    if (cmd.init_cand) cand <= n >> 1;
    if (cmd.next_cand) cand <= cand + 1'b1;
    if (cmd.v_cand)    v <= cand;
    if (cmd.v_comp)    v <= comp;
    if (cmd.d_three)   d <= DW'(3);
    if (cmd.d_add2)    d <= d + DW'(2);
    if (cmd.d_adv)     d <= (d == DW'(3)) ? DW'(5) : d + DW'(4);
    if (cmd.write_out) begin
      larger_prime  <= found ? 16'(cand) : '0;
      smaller_prime <= found ? 16'(comp) : '0;
      status        <= cmd.result;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gpps_ctrl.sv
`default_nettype none
module gpps_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire gpps_pkg::stat_t st,
  output gpps_pkg::cmd_t      cmd
);
  import gpps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_CAND, S_CHECK, S_SQ, S_ISSUE, S_DIV, S_FINISH
  } state_t;

  state_t  state, state_next;
  logic    on_comp, on_comp_next;
  logic    first, first_next;
  status_t res, res_next;
  logic    pass, fail;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd          = '0;
    cmd.result   = res;
    state_next   = state;
    on_comp_next = on_comp;
    first_next   = first;
    res_next     = res;
    pass         = 1'b0;
    fail         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (st.invalid) begin
          res_next   = STATUS_INVALID;
          state_next = S_FINISH;
        end else begin
          cmd.init_cand = 1'b1;
          state_next    = S_CAND;
        end
      end
      S_CAND: begin
        if (st.cand_end) begin
          res_next   = STATUS_NO_PAIR;
          state_next = S_FINISH;
        end else if (st.comp_small) begin
          cmd.next_cand = 1'b1;
        end else begin
          cmd.v_cand   = 1'b1;
          on_comp_next = 1'b0;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.v_lt2) begin
          fail = 1'b1;
        end else if (st.v_le3) begin
          pass = 1'b1;
        end else if (st.v_even) begin
          fail = 1'b1;
        end else begin
          cmd.d_three = 1'b1;
          first_next  = 1'b0;
          state_next  = S_SQ;
        end
      end
      S_SQ: begin
        if (st.sq_over) pass = 1'b1;
        else state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.rem_zero) begin
            fail = 1'b1;
          end else if (first) begin
            // second divisor of the 6k-1, 6k+1 pair skips the bound check
            cmd.d_add2 = 1'b1;
            first_next = 1'b0;
            state_next = S_ISSUE;
          end else begin
            cmd.d_adv  = 1'b1;
            first_next = 1'b1;
            state_next = S_SQ;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (pass) begin
      if (on_comp) begin
        res_next   = STATUS_FOUND;
        state_next = S_FINISH;
      end else begin
        cmd.v_comp   = 1'b1;
        on_comp_next = 1'b1;
        state_next   = S_CHECK;
      end
    end
    if (fail) begin
      cmd.next_cand = 1'b1;
      state_next    = S_CAND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      on_comp   <= 1'b0;
      first     <= 1'b0;
      res       <= STATUS_NO_PAIR;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      on_comp <= on_comp_next;
      first   <= first_next;
      res     <= res_next;
      if (cmd.write_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/goldbach_prime_pair_search.sv
// Latency: data dependent; set by how many candidates are tried and how many trial
// divisions each candidate needs.
// Throughput: one request at a time; the next is taken once the search of the
// current one ends, while its result may still wait in the output register.
// Reset: synchronous rst clears the controller and the output valid flag.
`default_nettype none
module goldbach_prime_pair_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] target
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] larger_prime, [31:16] smaller_prime
  output logic [1:0]       m_tuser    // [1:0] status
);
  import gpps_pkg::*;

  `include "goldbach_prime_pair_search_macros.svh"

  cmd_t    cmd;
  stat_t   st;
  status_t status;

  gpps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gpps_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .target       (s_tdata),
    .larger_prime (m_tdata[15:0]),
    .smaller_prime(m_tdata[31:16]),
    .status       (status)
  );

  assign m_tuser = status;

  `GPPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `GPPS_ASSERT_NOW(a_pair_order, m_tvalid && m_tuser == STATUS_FOUND, m_tdata[15:0] >= m_tdata[31:16], "pair out of order")
  `GPPS_ASSERT_NOW(a_zero_unless_found, m_tvalid && m_tuser != STATUS_FOUND, m_tdata == '0, "nonzero primes without pair")

endmodule
`default_nettype wire

FILE: dv/goldbach_prime_pair_search_tb.sv
`default_nettype none
module goldbach_prime_pair_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpps_pkg::*;

  typedef struct {
    logic [15:0] larger;
    logic [15:0] smaller;
    status_t     status;
  } pair_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  logic [15:0] target_queue[$];
  pair_t       pair_queue[$];
  int          error_count;
  int          cycle_count;
  int          send_wait;
  int          recv_wait;
  int          hold_count;

  localparam int CYCLE_LIMIT = 20000000;

  goldbach_prime_pair_search u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_prime(int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    if (v <= 3) return 1'b1;
    if (v % 2 == 0 || v % 3 == 0) return 1'b0;
    for (d = 5; d * d <= v; d += 6)
      if (v % d == 0 || v % (d + 2) == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pair_t split_target(logic [15:0] target);
    pair_t       p;
    int unsigned n;
    int unsigned cand;
    n = 32'(target);
    p.larger  = '0;
    p.smaller = '0;
    p.status  = STATUS_NO_PAIR;
    if (n <= 2 || n[0]) begin
      p.status = STATUS_INVALID;
    end else begin
      for (cand = n / 2; cand < n; cand++) begin
        if (n - cand >= 2 && is_prime(cand) && is_prime(n - cand)) begin
          p.larger  = 16'(cand);
          p.smaller = 16'(n - cand);
          p.status  = STATUS_FOUND;
          break;
        end
      end
    end
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pair_queue.push_back(split_target(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0 || target_queue.size() == 0) begin
          s_tvalid <= 1'b0;
          if (send_wait > 0) send_wait <= send_wait - 1;
        end else begin
          s_tvalid  <= 1'b1;
          s_tdata   <= target_queue.pop_front();
          send_wait <= int'($urandom_range(0, 7));
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pair_t p;
    if (rst) begin
      m_tready  <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pair_queue.size() == 0) begin
          report("unexpected result", m_tdata, 0);
        end else begin
          p = pair_queue.pop_front();
          if (m_tdata[15:0] !== p.larger)
            report("larger_prime", 32'(m_tdata[15:0]), 32'(p.larger));
          if (m_tdata[31:16] !== p.smaller)
            report("smaller_prime", 32'(m_tdata[31:16]), 32'(p.smaller));
          if (m_tuser !== p.status)
            report("status", 32'(m_tuser), 32'(p.status));
        end
      end
      if (hold_count > 0) begin
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        m_tready  <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else if (m_tvalid && m_tready) begin
        recv_wait <= int'($urandom_range(0, 7));
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_count <= 0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
    end else if (cycle_count == 3000) begin
      hold_count <= 2000;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL goldbach_prime_pair_search");
      $finish;
    end
  end

  initial begin
    logic [15:0] t;
    int          i;
    error_count   = 0;
    cycle_count   = 0;
    hold_count    = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    // directed: invalid edges, smallest valid, largest values, all-ones and alternating-bit patterns, assorted evens
    target_queue = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd8, 16'd10,
                     16'd12, 16'd100, 16'd65534, 16'd65535, 16'd65532, 16'd32768,
                     16'd43690, 16'd21845, 16'd1024, 16'd998, 16'd30030};
    for (i = 0; i < 600; i++) begin
      t = 16'($urandom);
      case ($urandom_range(0, 9))
        0:       ;                                    // raw noise, often odd
        1, 2:    t = 16'($urandom_range(0, 64));      // small values
        default: t[0] = 1'b0;                        // well-formed even target
      endcase
      target_queue.push_back(t);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (target_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    while (s_tvalid || pair_queue.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    if (error_count == 0 && pair_queue.size() == 0) begin
      $display("PASS goldbach_prime_pair_search");
    end else begin
      $display("FAIL goldbach_prime_pair_search");
    end
    $finish;
  end
endmodule
`default_nettype wire
